[sv/rwc_pkg.sv]
// Shared types, constants and register codes for the ROI window classifier.
// No dependencies; every other file imports this package.
package rwc_pkg;

  // Region length limit and queue sizing
  localparam int MAX_REGION_TICKS = 4096;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  // Configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADC_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_SUM_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESCALE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESCALE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THRESH   = 3'd4;

  // Region classes
  localparam logic [1:0] CLASS_KEEP   = 2'd0;
  localparam logic [1:0] CLASS_FIT    = 2'd1;
  localparam logic [1:0] CLASS_REMOVE = 2'd2;

  // Charge and swing test constants
  localparam logic [17:0] CHARGE_PER_TICK = 18'd30;
  localparam logic signed [12:0] SWING_LIMIT = 13'sd22;

  // Live configuration
  typedef struct packed {
    logic [11:0] adc_threshold;
    logic [23:0] abs_sum_threshold;
    logic [15:0] rescale_q8;
    logic [15:0] rescale_limit_q8;
    logic [10:0] ratio_threshold_q10;
  } cfg_t;

  // Finished region handed from front to back
  typedef struct packed {
    logic signed [24:0] ssum;
    logic [23:0]        asum;
    logic [28:0]        qsum;
    logic signed [11:0] amax;
    logic signed [11:0] amin;
    logic [12:0]        ticks;
  } summary_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_SN,
    B_RA,
    B_RAS,
    B_AS,
    B_LN,
    B_DECIDE
  } back_state_t;

endpackage

[sv/rwc_front.sv]
// Front end: accumulates one region tick by tick with saturating sums.
// Depends on rwc_pkg; pushes a summary_t into the queue on the region's last tick.
module rwc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_accept,
  input  logic signed [11:0]    adc_sample,
  input  logic signed [17:0]    decon_charge,
  input  logic                  last_tick,
  input  logic [11:0]           adc_threshold,
  output logic                  push,
  output rwc_pkg::summary_t     push_data
);
  import rwc_pkg::*;

  logic signed [24:0] ssum_r, ssum_nxt;
  logic [23:0]        asum_r, asum_nxt;
  logic [28:0]        qsum_r, qsum_nxt;
  logic signed [11:0] amax_r, amax_nxt;
  logic signed [11:0] amin_r, amin_nxt;
  logic [12:0]        tick_r, tick_nxt;

  logic [11:0]        aadc;
  logic [17:0]        acharge;
  logic               qualify;
  logic signed [25:0] ssum_add;
  logic [24:0]        asum_add;
  logic [29:0]        qsum_add;
  logic               region_end;

  // Magnitudes; the most negative code maps to its unsigned magnitude
  assign aadc    = adc_sample[11] ? (~adc_sample + 12'd1) : adc_sample;
  assign acharge = decon_charge[17] ? (~decon_charge + 18'd1) : decon_charge;
  assign qualify = aadc > adc_threshold;

  assign ssum_add = {ssum_r[24], ssum_r} + {{14{adc_sample[11]}}, adc_sample};
  assign asum_add = {1'b0, asum_r} + {13'd0, aadc};
  assign qsum_add = {1'b0, qsum_r} + {12'd0, acharge};

  // Next region state for the tick now on the inputs
  always_comb begin
    ssum_nxt = ssum_r;
    asum_nxt = asum_r;
    qsum_nxt = qsum_r;
    if (qualify) begin
      // saturate on overflow
      if (ssum_add[25] != ssum_add[24]) begin
        ssum_nxt = ssum_add[25] ? {1'b1, 24'd0} : {1'b0, {24{1'b1}}};
      end else begin
        ssum_nxt = ssum_add[24:0];
      end
      asum_nxt = asum_add[24] ? {24{1'b1}} : asum_add[23:0];
      qsum_nxt = qsum_add[29] ? {29{1'b1}} : qsum_add[28:0];
    end
    amax_nxt = (adc_sample > amax_r) ? adc_sample : amax_r;
    amin_nxt = (adc_sample < amin_r) ? adc_sample : amin_r;
    tick_nxt = tick_r + 13'd1;
  end

  // Force a region end at the tick limit
  assign region_end = last_tick || (tick_nxt == 13'(MAX_REGION_TICKS));

  assign push = tick_accept && region_end;
  always_comb begin
    push_data.ssum  = ssum_nxt;
    push_data.asum  = asum_nxt;
    push_data.qsum  = qsum_nxt;
    push_data.amax  = amax_nxt;
    push_data.amin  = amin_nxt;
    push_data.ticks = tick_nxt;
  end

  // Advance on each tick, clear at region end
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      ssum_r <= '0;
      asum_r <= '0;
      qsum_r <= '0;
      amax_r <= -12'sd1;
      amin_r <= 12'sd1;
      tick_r <= '0;
    end else if (tick_accept) begin
      ssum_r <= ssum_nxt;
      asum_r <= asum_nxt;
      qsum_r <= qsum_nxt;
      amax_r <= amax_nxt;
      amin_r <= amin_nxt;
      tick_r <= tick_nxt;
    end
  end

endmodule

[sv/rwc_queue.sv]
// Short FIFO of finished region summaries between front and back end.
// Depends on rwc_pkg for summary_t and the queue depth.
module rwc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rwc_pkg::summary_t  push_data,
  input  logic               pop,
  output rwc_pkg::summary_t  pop_data,
  output logic               full,
  output logic               empty
);
  import rwc_pkg::*;

  summary_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = entry_r[rd_ptr_r];

  // Store pushed summaries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[sv/rwc_back.sv]
// Back end: classifies one region summary with one product per cycle.
// Depends on rwc_pkg; drives the registered result strobe and fields.
module rwc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rwc_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  rwc_pkg::summary_t  q_data,
  output logic               q_pop,
  output logic               res_valid,
  output logic [1:0]         res_class,
  output logic [23:0]        res_abs_total,
  output logic [12:0]        res_ticks
);
  import rwc_pkg::*;

  back_state_t state_r, state_nxt;

  summary_t           sum_r;
  logic signed [37:0] p_sn_r;
  logic [34:0]        p_ra_r;
  logic [50:0]        p_rhs_r;
  logic [39:0]        p_as_r;
  logic [28:0]        p_ln_r;

  logic               valid_r;
  logic [1:0]         class_r;
  logic [23:0]        abs_total_r;
  logic [12:0]        ticks_r;

  logic signed [37:0] sn_a, sn_b;
  logic signed [56:0] lhs, rhs;
  logic [17:0]        n30;
  logic signed [12:0] swing;
  logic               fit_ok, mean_low, charge_ok;
  logic [1:0]         class_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one region through the product steps
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_SN;
        end
      end
      B_SN:     state_nxt = B_RA;
      B_RA:     state_nxt = B_RAS;
      B_RAS:    state_nxt = B_AS;
      B_AS:     state_nxt = B_LN;
      B_LN:     state_nxt = B_DECIDE;
      B_DECIDE: state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  assign sn_a = 38'(sum_r.ssum);
  assign sn_b = $signed({25'd0, sum_r.ticks});

  // Products, one per step
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE:  if (q_pop) sum_r <= q_data;
      B_SN:    p_sn_r  <= sn_a * sn_b;
      B_RA:    p_ra_r  <= 35'(cfg.ratio_threshold_q10) * 35'(sum_r.asum);
      B_RAS:   p_rhs_r <= 51'(p_ra_r) * 51'(cfg.rescale_q8);
      B_AS:    p_as_r  <= 40'(sum_r.asum) * 40'(cfg.rescale_q8);
      B_LN:    p_ln_r  <= 29'(cfg.rescale_limit_q8) * 29'(sum_r.ticks);
      default: sum_r   <= sum_r;
    endcase
  end

  // Final tests, first match wins
  assign lhs       = {p_sn_r[37], p_sn_r, 18'd0};
  assign rhs       = $signed({6'd0, p_rhs_r});
  assign n30       = 18'(sum_r.ticks) * CHARGE_PER_TICK;
  assign swing     = 13'(sum_r.amax) - 13'(sum_r.amin);
  assign fit_ok    = (lhs > rhs) && (sum_r.asum > cfg.abs_sum_threshold);
  assign mean_low  = p_as_r < {11'd0, p_ln_r};
  assign charge_ok = (sum_r.qsum > {11'd0, n30}) &&
                     (sum_r.asum < {10'd0, sum_r.ticks, 1'b0}) &&
                     (swing < SWING_LIMIT);

  always_comb begin
    if (fit_ok) begin
      class_nxt = CLASS_FIT;
    end else if (mean_low || charge_ok) begin
      class_nxt = CLASS_REMOVE;
    end else begin
      class_nxt = CLASS_KEEP;
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= state_r == B_DECIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_DECIDE) begin
      class_r     <= class_nxt;
      abs_total_r <= sum_r.asum;
      ticks_r     <= sum_r.ticks;
    end
  end

  assign res_valid     = valid_r;
  assign res_class     = class_r;
  assign res_abs_total = abs_total_r;
  assign res_ticks     = ticks_r;

endmodule

[sv/roi_window_classifier_top.sv]
// Top level of the ROI window classifier: configuration registers, front end,
// summary queue and back end. Depends on rwc_pkg, rwc_front, rwc_queue, rwc_back.
//
//   channel   handshake          payload
//   in_       start / busy       in_adc_sample, in_decon_charge, in_last_tick
//   out_      out_valid strobe   out_region_class, out_abs_adc_total, out_tick_total
//   cfg_      cfg_we             cfg_index, cfg_data
//
// One tick is taken per cycle while busy is low. A region's result appears once the
// back end's product sequencer has run (one product per step in SN, RA, RAS, AS and LN,
// then DECIDE); the back end pops no new region until it is back in idle.
// busy rises only while two finished regions wait in the queue.
// Reset is synchronous: it clears the sums, the queue and the sequencer and
// loads the default register values. The result strobe cannot be stalled.
module roi_window_classifier_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [11:0]               in_adc_sample,
  input  logic signed [17:0]               in_decon_charge,
  input  logic                             in_last_tick,
  output logic                             out_valid,
  output logic [1:0]                       out_region_class,
  output logic [23:0]                      out_abs_adc_total,
  output logic [12:0]                      out_tick_total,
  input  logic                             cfg_we,
  input  logic [rwc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rwc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rwc_pkg::*;

  cfg_t     cfg_r;
  logic     tick_accept;
  logic     push, pop, q_full, q_empty;
  summary_t push_data, pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_threshold       <= 12'd6;
      cfg_r.abs_sum_threshold   <= 24'd160;
      cfg_r.rescale_q8          <= 16'd23040;
      cfg_r.rescale_limit_q8    <= 16'd12800;
      cfg_r.ratio_threshold_q10 <= 11'd205;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADC_THRESHOLD:  cfg_r.adc_threshold       <= cfg_data[11:0];
        REG_ABS_SUM_THRESH: cfg_r.abs_sum_threshold   <= cfg_data[23:0];
        REG_RESCALE:        cfg_r.rescale_q8          <= cfg_data[15:0];
        REG_RESCALE_LIMIT:  cfg_r.rescale_limit_q8    <= cfg_data[15:0];
        REG_RATIO_THRESH:   cfg_r.ratio_threshold_q10 <= cfg_data[10:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  // Accept a tick whenever the queue has room
  assign busy        = q_full;
  assign tick_accept = start && !busy;

  rwc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_accept   (tick_accept),
    .adc_sample    (in_adc_sample),
    .decon_charge  (in_decon_charge),
    .last_tick     (in_last_tick),
    .adc_threshold (cfg_r.adc_threshold),
    .push          (push),
    .push_data     (push_data)
  );

  rwc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rwc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (pop),
    .res_valid     (out_valid),
    .res_class     (out_region_class),
    .res_abs_total (out_abs_adc_total),
    .res_ticks     (out_tick_total)
  );

endmodule

[sv/rwc_checker.sv]
// Port-level checks for the ROI window classifier, bound to the top level.
// Depends on the top level's ports and on rwc_pkg for the class codes.
module rwc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [1:0]  out_region_class,
  input logic [23:0] out_abs_adc_total,
  input logic [12:0] out_tick_total
);
  import rwc_pkg::*;

  // Result beats are spaced by the back-end sequence
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats on consecutive cycles");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // Class code stays in range
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region_class <= CLASS_REMOVE))
    else $error("undefined region class");

  // Every region has at least one tick
  a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tick_total != 13'd0))
    else $error("region with zero ticks");

  // Fit class implies a nonzero absolute sum
  a_fit_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region_class == CLASS_FIT) |-> (out_abs_adc_total != 24'd0))
    else $error("fit class with empty absolute sum");

endmodule

bind roi_window_classifier_top rwc_checker u_rwc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_region_class  (out_region_class),
  .out_abs_adc_total (out_abs_adc_total),
  .out_tick_total    (out_tick_total)
);

[tb/sv/tb_roi_window_classifier_top.sv]
// Testbench for roi_window_classifier_top: a queued tick driver, a result monitor and a
// region classifier model that predicts every region verdict. Depends on rwc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_roi_window_classifier_top;
  import rwc_pkg::*;

  typedef struct {
    logic signed [11:0] adc;
    logic signed [17:0] charge;
    logic               last;
    int                 gap;
  } tick_beat_t;

  typedef struct {
    logic [1:0]  region_class;
    logic [23:0] abs_total;
    logic [12:0] ticks;
  } region_verdict_t;

  typedef enum int {KIND_PULSE, KIND_QUIET, KIND_RAW} region_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [11:0]    in_adc_sample = '0;
  logic signed [17:0]    in_decon_charge = '0;
  logic                  in_last_tick = 1'b0;
  logic                  out_valid;
  logic [1:0]            out_region_class;
  logic [23:0]           out_abs_adc_total;
  logic [12:0]           out_tick_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tick_beat_t      ticks_pending[$];
  region_verdict_t verdicts_due[$];
  bit              tick_taken = 1'b0;
  bit              burst_run = 1'b0;
  int              mismatches = 0;

  // Model copy of the registers and the open region
  cfg_t   live_cfg;
  longint run_ssum, run_asum, run_qsum;
  int     run_max, run_min, run_ticks;

  always #1 clk = ~clk;

  roi_window_classifier_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_adc_sample     (in_adc_sample),
    .in_decon_charge   (in_decon_charge),
    .in_last_tick      (in_last_tick),
    .out_valid         (out_valid),
    .out_region_class  (out_region_class),
    .out_abs_adc_total (out_abs_adc_total),
    .out_tick_total    (out_tick_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_region_model();
    run_ssum = 0;
    run_asum = 0;
    run_qsum = 0;
    run_max = -1;
    run_min = 1;
    run_ticks = 0;
  endtask

  // Fold one accepted tick into the region; on the closing tick classify and queue the verdict
  task automatic absorb_tick(input logic signed [11:0] adc, input logic signed [17:0] chg,
                             input logic last_in);
    longint adc_v, chg_v, adc_mag, chg_mag, n, thr, abs_thr, rs, lim, ratio, lhs, rhs;
    region_verdict_t verdict;
    bit closes;
    adc_v = adc;
    chg_v = chg;
    adc_mag = (adc_v < 0) ? -adc_v : adc_v;
    chg_mag = (chg_v < 0) ? -chg_v : chg_v;
    thr = live_cfg.adc_threshold;
    abs_thr = live_cfg.abs_sum_threshold;
    rs = live_cfg.rescale_q8;
    lim = live_cfg.rescale_limit_q8;
    ratio = live_cfg.ratio_threshold_q10;
    closes = last_in;

    if (adc_v > run_max) run_max = adc_v;
    if (adc_v < run_min) run_min = adc_v;

    // Only ticks above the magnitude threshold enter the saturating sums
    if (adc_mag > thr) begin
      run_ssum = clip(run_ssum + adc_v, -longint'(16777216), longint'(16777215));
      run_asum = clip(run_asum + adc_mag, 0, longint'(16777215));
      run_qsum = clip(run_qsum + chg_mag, 0, longint'(536870911));
    end

    // Force the region closed at the length limit
    if (run_ticks < MAX_REGION_TICKS) run_ticks++;
    if (run_ticks >= MAX_REGION_TICKS) closes = 1'b1;
    if (!closes) return;

    n = run_ticks;
    lhs = run_ssum * n * 262144;
    rhs = ratio * run_asum * rs;
    if (lhs > rhs && run_asum > abs_thr) begin
      verdict.region_class = CLASS_FIT;
    end else if (run_asum * rs < lim * n) begin
      verdict.region_class = CLASS_REMOVE;
    end else if (run_qsum > longint'(CHARGE_PER_TICK) * n && run_asum < 2 * n &&
                 run_max - run_min < SWING_LIMIT) begin
      verdict.region_class = CLASS_REMOVE;
    end else begin
      verdict.region_class = CLASS_KEEP;
    end
    verdict.abs_total = run_asum[23:0];
    verdict.ticks = n[12:0];
    verdicts_due.insert(verdicts_due.size(), verdict);
    clear_region_model();
  endtask

  // Take a beat whenever start meets a free block
  always @(posedge clk) begin
    tick_taken = rst_n && start && !busy;
    if (tick_taken) absorb_tick(in_adc_sample, in_decon_charge, in_last_tick);
  end

  // Compare each strobed result against the oldest pending verdict
  always @(posedge clk) begin : result_monitor
    region_verdict_t want;
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result strobe with no region pending");
      end else begin
        want = verdicts_due.pop_front();
        if (out_region_class !== want.region_class)
          report_mismatch($sformatf("region_class %0d, want %0d",
                                    out_region_class, want.region_class));
        if (out_abs_adc_total !== want.abs_total)
          report_mismatch($sformatf("abs_adc_total %0d, want %0d",
                                    out_abs_adc_total, want.abs_total));
        if (out_tick_total !== want.ticks)
          report_mismatch($sformatf("tick_total %0d, want %0d", out_tick_total, want.ticks));
      end
    end
  end

  // Present queued ticks; hold a beat until taken, idle through each beat's gap
  always @(negedge clk) begin : tick_driver
    tick_beat_t nxt;
    if (start && !tick_taken) begin
      // hold the current beat
    end else if (ticks_pending.size() == 0) begin
      start <= 1'b0;
    end else if (ticks_pending[0].gap > 0) begin
      ticks_pending[0].gap = ticks_pending[0].gap - 1;
      start <= 1'b0;
    end else begin
      nxt = ticks_pending.pop_front();
      start <= 1'b1;
      in_adc_sample <= nxt.adc;
      in_decon_charge <= nxt.charge;
      in_last_tick <= nxt.last;
    end
  end

  // Queue one tick with an idle gap in front: mostly none, some short, a few long
  task automatic push_tick(input logic signed [11:0] adc, input logic signed [17:0] chg,
                           input logic last_in);
    tick_beat_t beat;
    int r;
    beat.adc = adc;
    beat.charge = chg;
    beat.last = last_in;
    r = $urandom_range(0, 99);
    if (burst_run || r < 65) beat.gap = 0;
    else if (r < 92) beat.gap = $urandom_range(1, 3);
    else beat.gap = $urandom_range(8, 40);
    ticks_pending.insert(ticks_pending.size(), beat);
  endtask

  // Queue one well-formed region of the given shape and length
  task automatic queue_region(input region_kind_t kind, input int len);
    int mag, span, step;
    bit neg;
    logic signed [11:0] adc;
    burst_run = ($urandom_range(0, 3) == 0);
    neg = ($urandom_range(0, 9) < 3);
    case ($urandom_range(0, 2))
      0: span = 63;
      1: span = 511;
      default: span = 2047;
    endcase
    step = (live_cfg.adc_threshold < 2047) ? live_cfg.adc_threshold + 1 : 2047;
    for (int i = 0; i < len; i++) begin
      case (kind)
        KIND_PULSE: begin
          mag = $urandom_range(0, span);
          adc = 12'(neg ? -mag : mag);
        end
        KIND_QUIET: begin
          // sparse ticks just over the threshold, to reach the charge and swing test
          if ($urandom_range(0, 3) == 0) adc = 12'($urandom_range(0, 1) ? -step : step);
          else adc = '0;
        end
        default: adc = 12'($urandom);
      endcase
      push_tick(adc, 18'($urandom), i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ADC_THRESHOLD:  live_cfg.adc_threshold = val[11:0];
      REG_ABS_SUM_THRESH: live_cfg.abs_sum_threshold = val[23:0];
      REG_RESCALE:        live_cfg.rescale_q8 = val[15:0];
      REG_RESCALE_LIMIT:  live_cfg.rescale_limit_q8 = val[15:0];
      REG_RATIO_THRESH:   live_cfg.ratio_threshold_q10 = val[10:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [23:0] thr, input logic [23:0] abs_thr,
                             input logic [23:0] rs, input logic [23:0] lim,
                             input logic [23:0] ratio);
    write_reg(REG_ADC_THRESHOLD, thr);
    write_reg(REG_ABS_SUM_THRESH, abs_thr);
    write_reg(REG_RESCALE, rs);
    write_reg(REG_RESCALE_LIMIT, lim);
    write_reg(REG_RATIO_THRESH, ratio);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every tick is taken and every verdict has arrived, then let the pipe settle
  task automatic wait_idle();
    while (ticks_pending.size() != 0 || start || verdicts_due.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int made, len, r;
    region_kind_t kind;
    live_cfg.adc_threshold = 12'd6;
    live_cfg.abs_sum_threshold = 24'd160;
    live_cfg.rescale_q8 = 16'd23040;
    live_cfg.rescale_limit_q8 = 16'd12800;
    live_cfg.ratio_threshold_q10 = 11'd205;
    clear_region_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, empty sums, charge and swing removal, a narrow fit
    push_tick(12'(-2048), 18'(-131072), 1'b1);
    push_tick(12'sd0, 18'sd0, 1'b1);
    push_tick(12'sd7, 18'sd1000, 1'b0);
    push_tick(12'sd0, 18'(-5), 1'b0);
    push_tick(12'sd6, 18'(-131072), 1'b0);
    push_tick(12'sd0, 18'sd0, 1'b1);
    push_tick(12'sd2047, 18'sd131071, 1'b0);
    for (int i = 0; i < 17; i++) push_tick(12'sd100, 18'sd0, 1'b0);
    push_tick(12'(-7), 18'sd0, 1'b1);
    wait_idle();

    // Overlong region: forced close at the length limit, charge sum saturates
    for (int i = 0; i <= MAX_REGION_TICKS; i++) push_tick(12'(-2048), 18'(-131072), 1'b0);
    push_tick(12'sd5, 18'sd3, 1'b1);
    wait_idle();

    // Random regions under reset values, extremes and random register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: ;
        1: load_config(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        2: load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        3: load_config(24'd0, 24'd0, 24'd256, 24'd256, 24'd1024);
        4: load_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom));
        default: load_config(24'($urandom_range(0, 40)), 24'($urandom_range(0, 4000)),
                             24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
                             24'($urandom_range(0, 1024)));
      endcase
      made = 0;
      while (made < 125) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 4);
        else if (r < 92) len = $urandom_range(5, 30);
        else len = $urandom_range(31, 120);
        r = $urandom_range(0, 99);
        if (r < 45) kind = KIND_PULSE;
        else if (r < 75) kind = KIND_QUIET;
        else kind = KIND_RAW;
        queue_region(kind, len);
        made += len;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
